@@ sv/spdg_pkg.sv @@
// shared types and constants for the dense-graph shortest-path core
package spdg_pkg;

	localparam int DIST_BITS   = 22;
	localparam int VERTEX_BITS = 4;
	localparam int TABLE_DEPTH = 16;

	typedef logic [DIST_BITS-1:0] dist_t;

	localparam dist_t DIST_INF = 22'h3FFFFF;
	localparam dist_t DIST_SAT = 22'h3FFFFE;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_RUN   = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PICK,
		ST_READ,
		ST_RELAX,
		ST_OUT
	} state_t;

	typedef enum logic {
		OP_PICK,
		OP_RELAX
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
		logic    done;
		dist_t   dist_v;
		dist_t   best;
	} alu_req_t;

	typedef struct packed {
		logic  take;
		dist_t value;
	} alu_rsp_t;

endpackage

@@ sv/spdg_alu.sv @@
// shared add and compare unit: minimum search step and edge relaxation step
module spdg_alu
	import spdg_pkg::*;
#(
	parameter int WEIGHT_BITS = 16
) (
	input  alu_req_t               req,
	input  logic [WEIGHT_BITS-1:0] weight,
	output alu_rsp_t               rsp
);

	localparam int SUM_BITS = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

	logic [SUM_BITS-1:0] sum;
	dist_t               sum_sat;

	always_comb begin
		sum     = SUM_BITS'(req.best) + SUM_BITS'(weight);
		// saturate one below the unreachable code
		sum_sat = (sum > SUM_BITS'(DIST_SAT)) ? DIST_SAT : sum[DIST_BITS-1:0];
	end

	always_comb begin
		unique case (req.op)
			OP_PICK: begin
				rsp.take  = !req.done && (req.dist_v <= req.best);
				rsp.value = req.dist_v;
			end
			OP_RELAX: begin
				rsp.take  = !req.done && (weight != '0) && (sum_sat < req.dist_v);
				rsp.value = sum_sat;
			end
			default: begin
				rsp.take  = 1'b0;
				rsp.value = req.dist_v;
			end
		endcase
	end

endmodule

@@ sv/shortest_path_dense_graph_core.sv @@
// top level of the dense-graph single-source shortest-path core
// Usage:
//   Input stream s_*: tuser is the command (0 writes one matrix entry, 1 runs a search).
//   A matrix write is taken while the core is idle; a back-to-back stream of writes then goes at one per cycle.
//   A run walks the weight memory under a small sequencer with one shared add/compare
//   unit: n-1 rounds, each a minimum scan over the n vertices plus, when the picked vertex is
//   reachable, a relaxation pass over the n neighbours (one memory read and one relax per neighbour).
//   Here n is the clamped vertex count; s_tready stays low throughout the run.
//   Output stream m_*: one transfer per vertex in index order, tlast on vertex n-1.
//   Results go out through an output register; when the receiver stalls the sequencer
//   waits with the next result and the core takes no new item until all are loaded.
//   cfg_we/cfg_wdata write the vertex count; write it only while the core is idle.
//   Reset: the vertex count returns to 16 and a clearing pass zeroes the weight memory,
//   one entry a cycle, all 2^(2*ceil(log2(min(MAX_VERTICES,16)))) entries (256 by default);
//   s_tready stays low until it is over.
module shortest_path_dense_graph_core
	import spdg_pkg::*;
#(
	parameter int MAX_VERTICES = 16,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// row_vertex[3:0], col_vertex[7:4], edge_weight[23:8], source_vertex[27:24]
	input  logic [31:0] s_tdata,
	// cmd[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// vertex_index[3:0], path_distance[25:4], reachable[26]
	output logic [31:0] m_tdata,
	output logic        m_tlast
);

	localparam int NV        = (MAX_VERTICES < TABLE_DEPTH) ? MAX_VERTICES : TABLE_DEPTH;
	localparam int VB        = $clog2(NV);
	localparam int AW        = 2 * VB;
	localparam int MEM_DEPTH = 1 << AW;
	localparam logic [4:0] NV_COUNT = 5'(NV);

	state_t state_q, state_d;

	logic [4:0]             vcount_q;
	logic [AW-1:0]          clr_addr_q;
	logic [VB-1:0]          v_q;
	logic [VB-1:0]          u_q;
	logic [VB-1:0]          u_d;
	logic [VB-1:0]          round_q;
	logic [VB-1:0]          nm1_q;
	logic [NV-1:0]          done_q;
	dist_t                  best_q;
	dist_t                  best_d;
	dist_t                  dist_q [NV];
	logic                   m_tvalid_q;
	logic [31:0]            m_tdata_q;
	logic                   m_tlast_q;

	logic [WEIGHT_BITS-1:0] wmem_q [MEM_DEPTH];
	logic [WEIGHT_BITS-1:0] rdata_q;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [WEIGHT_BITS-1:0] mem_wdata;

	logic [3:0]             in_row;
	logic [3:0]             in_col;
	logic [15:0]            in_weight;
	logic [3:0]             in_src;
	logic                   s_accept;
	logic                   run_start;
	logic [4:0]             run_n;
	logic [VB-1:0]          run_nm1;
	logic                   src_ok;
	logic                   v_last;
	logic                   round_last;
	logic                   out_load;
	dist_t                  dist_v;
	alu_req_t               alu_req;
	alu_rsp_t               alu_rsp;

	assign in_row    = s_tdata[3:0];
	assign in_col    = s_tdata[7:4];
	assign in_weight = s_tdata[23:8];
	assign in_src    = s_tdata[27:24];

	assign s_accept  = s_tvalid && s_tready;
	assign run_start = s_accept && (s_tuser == CMD_RUN);

	// clamp the vertex count into 1..NV
	always_comb begin
		if (vcount_q == 5'd0) begin
			run_n = 5'd1;
		end else if (vcount_q > NV_COUNT) begin
			run_n = NV_COUNT;
		end else begin
			run_n = vcount_q;
		end
		run_nm1 = VB'(run_n - 5'd1);
		src_ok  = {1'b0, in_src} < run_n;
	end

	assign v_last     = (v_q == nm1_q);
	assign round_last = ((round_q + 1'b1) == nm1_q);
	assign dist_v     = dist_q[v_q];

	spdg_alu #(
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_alu (
		.req    (alu_req),
		.weight (rdata_q),
		.rsp    (alu_rsp)
	);

	always_comb begin
		alu_req.op     = (state_q == ST_RELAX) ? OP_RELAX : OP_PICK;
		alu_req.done   = done_q[v_q];
		alu_req.dist_v = dist_v;
		alu_req.best   = best_q;
	end

	// running minimum of the scan, highest index wins a tie
	always_comb begin
		best_d = best_q;
		u_d    = u_q;
		if (alu_rsp.take) begin
			best_d = alu_rsp.value;
			u_d    = v_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (run_start) state_d = (run_nm1 == '0) ? ST_OUT : ST_PICK;
			end
			ST_PICK: begin
				if (v_last) begin
					if (best_d != DIST_INF) begin
						state_d = ST_READ;
					end else begin
						state_d = round_last ? ST_OUT : ST_PICK;
					end
				end
			end
			ST_READ: begin
				state_d = ST_RELAX;
			end
			ST_RELAX: begin
				if (v_last) begin
					state_d = round_last ? ST_OUT : ST_PICK;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_OUT: begin
				if (out_load && v_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// handshake and memory write port
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
		mem_we    = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (s_accept && (s_tuser == CMD_WRITE)) begin
			mem_we    = ({1'b0, in_row} < NV_COUNT) && ({1'b0, in_col} < NV_COUNT);
			mem_waddr = {in_row[VB-1:0], in_col[VB-1:0]};
			mem_wdata = WEIGHT_BITS'(in_weight);
		end
	end

	// weight memory, registered read at row u, column v
	always_ff @(posedge clk) begin
		if (mem_we) wmem_q[mem_waddr] <= mem_wdata;
		rdata_q <= wmem_q[{u_q, v_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			vcount_q   <= 5'd16;
			clr_addr_q <= '0;
			v_q        <= '0;
			round_q    <= '0;
			nm1_q      <= '0;
			done_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) vcount_q <= cfg_wdata;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
				ST_IDLE: begin
					if (run_start) begin
						v_q     <= '0;
						round_q <= '0;
						nm1_q   <= run_nm1;
						done_q  <= '0;
					end
				end
				ST_PICK: begin
					if (v_last) begin
						done_q[u_d] <= 1'b1;
						v_q         <= '0;
						// an unreachable pick ends the round without relaxing
						if (best_d == DIST_INF && !round_last) round_q <= round_q + 1'b1;
					end else begin
						v_q <= v_q + 1'b1;
					end
				end
				ST_READ: begin
				end
				ST_RELAX: begin
					if (v_last) begin
						v_q <= '0;
						if (!round_last) round_q <= round_q + 1'b1;
					end else begin
						v_q <= v_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_load) v_q <= v_last ? '0 : v_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (run_start) begin
					for (int i = 0; i < NV; i++) begin
						dist_q[i] <= (src_ok && (int'(in_src) == i)) ? '0 : DIST_INF;
					end
					best_q <= DIST_INF;
				end
			end
			ST_PICK: begin
				best_q <= best_d;
				u_q    <= u_d;
			end
			ST_RELAX: begin
				if (alu_rsp.take) dist_q[v_q] <= alu_rsp.value;
				if (v_last) best_q <= DIST_INF;
			end
			ST_OUT: begin
				if (out_load) begin
					m_tdata_q <= {5'b0, (dist_v != DIST_INF), dist_v, VERTEX_BITS'(v_q)};
					m_tlast_q <= v_last;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// one vertex is marked processed per round
	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK) |-> ($countones(done_q) == int'(round_q)))
		else $error("processed count out of step with round");

	// relaxation runs only from a vertex already marked processed
	a_relax_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RELAX) |-> done_q[u_q])
		else $error("relaxing from an unprocessed vertex");

	// a new result only comes out of the output phase
	a_out_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load == 1'b0 && !m_tvalid_q) |=> !m_tvalid_q)
		else $error("result raised outside the output phase");

	// no input is taken during the clearing pass or the pick and relax states of a run
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR || state_q == ST_PICK || state_q == ST_RELAX) |-> !s_tready)
		else $error("input ready while busy");

endmodule

@@ tb/shortest_path_checker.sv @@
// checker for the shortest-path core: models the graph, predicts each search and compares results
module shortest_path_checker
	import spdg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// row_vertex[3:0], col_vertex[7:4], edge_weight[23:8], source_vertex[27:24]
	input  logic [31:0] s_tdata,
	// cmd[0]
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// vertex_index[3:0], path_distance[25:4], reachable[26]
	input  logic [31:0] m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending_results,
	output int          results_checked
);

	localparam int GRAPH_SIZE = 16;

	typedef struct packed {
		logic [VERTEX_BITS-1:0] vertex;
		dist_t                  path_dist;
		logic                   reachable;
		logic                   last;
	} vertex_result_t;

	logic [15:0]    edge_weights [GRAPH_SIZE][GRAPH_SIZE];
	logic [4:0]     vertex_count;
	vertex_result_t expected_paths [$];
	vertex_result_t got;
	vertex_result_t want;

	task report_mismatch(input string msg);
		fail_count++;
		$display("shortest_path_checker: %s", msg);
	endtask

	// dijkstra over the first n vertices, highest index wins a tie on the pick
	task automatic compute_distances(input logic [VERTEX_BITS-1:0] src);
		dist_t                  dist_tab [TABLE_DEPTH];
		logic [TABLE_DEPTH-1:0] settled;
		dist_t                  best;
		logic [DIST_BITS:0]     sum;
		vertex_result_t         res;
		int                     n;
		int                     u;
		int                     v;
		int                     rnd;
		n = (vertex_count == 0) ? 1 : (vertex_count > GRAPH_SIZE) ? GRAPH_SIZE : vertex_count;
		for (v = 0; v < TABLE_DEPTH; v++)
			dist_tab[v] = DIST_INF;
		settled = '0;
		if (src < n)
			dist_tab[src] = '0;
		for (rnd = 0; rnd < n - 1; rnd++) begin
			best = DIST_INF;
			u = 0;
			for (v = 0; v < n; v++) begin
				if (!settled[v] && dist_tab[v] <= best) begin
					best = dist_tab[v];
					u = v;
				end
			end
			settled[u] = 1'b1;
			if (dist_tab[u] != DIST_INF) begin
				for (v = 0; v < n; v++) begin
					if (!settled[v] && edge_weights[u][v] != 0) begin
						sum = {1'b0, dist_tab[u]} + edge_weights[u][v];
						// saturate one below the unreachable code
						if (sum > DIST_SAT)
							sum = DIST_SAT;
						if (sum < dist_tab[v])
							dist_tab[v] = sum[DIST_BITS-1:0];
					end
				end
			end
		end
		for (v = 0; v < n; v++) begin
			res.vertex = v[VERTEX_BITS-1:0];
			res.path_dist = dist_tab[v];
			res.reachable = (dist_tab[v] != DIST_INF);
			res.last = (v == n - 1);
			expected_paths.push_back(res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < GRAPH_SIZE; r++)
				for (int c = 0; c < GRAPH_SIZE; c++)
					edge_weights[r][c] = '0;
			vertex_count = 5'd16;
			expected_paths.delete();
			pending_results = 0;
		end else begin
			if (cfg_we)
				vertex_count = cfg_wdata;
			if (s_tvalid && s_tready) begin
				if (s_tuser == CMD_RUN)
					compute_distances(s_tdata[27:24]);
				else
					edge_weights[s_tdata[3:0]][s_tdata[7:4]] = s_tdata[23:8];
			end
			if (m_tvalid && m_tready) begin
				got.vertex = m_tdata[3:0];
				got.path_dist = m_tdata[25:4];
				got.reachable = m_tdata[26];
				got.last = m_tlast;
				if (expected_paths.size() == 0) begin
					report_mismatch($sformatf("result transfer for vertex %0d with none pending",
						got.vertex));
				end else begin
					want = expected_paths.pop_front();
					results_checked++;
					if (got.vertex !== want.vertex)
						report_mismatch($sformatf("vertex_index expected %0d got %0d",
							want.vertex, got.vertex));
					if (got.path_dist !== want.path_dist)
						report_mismatch($sformatf("vertex %0d path_distance expected %0d got %0d",
							want.vertex, want.path_dist, got.path_dist));
					if (got.reachable !== want.reachable)
						report_mismatch($sformatf("vertex %0d reachable expected %0d got %0d",
							want.vertex, want.reachable, got.reachable));
					if (got.last !== want.last)
						report_mismatch($sformatf("vertex %0d tlast expected %0d got %0d",
							want.vertex, want.last, got.last));
					if (m_tdata[31:27] !== '0)
						report_mismatch($sformatf("vertex %0d tdata padding not zero: %b",
							want.vertex, m_tdata[31:27]));
				end
			end
			pending_results = expected_paths.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
// testbench top for the shortest-path core: clock, reset, stimulus and verdict
module tb_top
	import spdg_pkg::*;
();

	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 9;
	localparam int PHASE_COUNTS [PHASES] = '{16, 5, 1, 9, 0, 31, 2, 12};
	// none, sender idle, receiver stall, both
	localparam int SENDER_PCT [4] = '{0, 83, 0, 31};
	localparam int RECEIVER_PCT [4] = '{0, 0, 83, 31};
	localparam int SEARCH_CYCLES = 800;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;

	int fail_count;
	int pending_results;
	int results_checked;
	int sender_idle_pct;
	int receiver_stall_pct;
	int items_sent;
	int searches_sent;
	bit pressure_done;

	shortest_path_dense_graph_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	shortest_path_checker path_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.fail_count     (fail_count),
		.pending_results(pending_results),
		.results_checked(results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= receiver_stall_pct);
	end

	task automatic send_item(input logic cmd, input logic [3:0] row, input logic [3:0] col,
		input logic [15:0] weight, input logic [3:0] src);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid = 1'b0;
			s_tdata = $urandom;
			s_tuser = 1'($urandom_range(1));
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = {4'b0, src, weight, col, row};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		if (cmd == CMD_RUN)
			searches_sent++;
	endtask

	task automatic wait_for_results();
		s_tvalid = 1'b0;
		while (pending_results != 0)
			@(negedge clk);
	endtask

	task automatic set_vertex_count(input logic [4:0] count);
		wait_for_results();
		// a write item can still be in flight after the last result
		repeat (16) @(negedge clk);
		while (!s_tready)
			@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = count;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// a few edge writes, mostly inside the live vertices, then one search
	task automatic random_search(input int n);
		int          writes;
		int          kind;
		logic [3:0]  row;
		logic [3:0]  col;
		logic [3:0]  src;
		logic [15:0] weight;
		writes = $urandom_range(6);
		repeat (writes) begin
			row = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(n - 1));
			col = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(n - 1));
			kind = $urandom_range(7);
			case (kind)
				0: weight = '0;
				1: weight = 16'($urandom);
				2: weight = 16'(16'hFFFF - $urandom_range(15));
				default: weight = 16'($urandom_range(1, 40));
			endcase
			send_item(CMD_WRITE, row, col, weight, 4'($urandom_range(15)));
		end
		src = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(n - 1));
		send_item(CMD_RUN, 4'($urandom_range(15)), 4'($urandom_range(15)), 16'($urandom), src);
	endtask

	initial begin
		int n;
		int phase_start;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_WRITE;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		items_sent = 0;
		searches_sent = 0;
		pressure_done = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		// clearing pass of the weight memory
		while (!s_tready)
			@(negedge clk);

		// directed: empty graph at the reset vertex count
		send_item(CMD_RUN, 4'd0, 4'd0, 16'd0, 4'd0);
		// equal distances to 1 and 2, then both lead to 3
		send_item(CMD_WRITE, 4'd0, 4'd1, 16'd3, 4'd0);
		send_item(CMD_WRITE, 4'd0, 4'd2, 16'd3, 4'd0);
		send_item(CMD_WRITE, 4'd1, 4'd3, 16'd1, 4'd0);
		send_item(CMD_WRITE, 4'd2, 4'd3, 16'd1, 4'd0);
		send_item(CMD_WRITE, 4'd3, 4'd15, 16'hFFFF, 4'd15);
		send_item(CMD_WRITE, 4'd15, 4'd14, 16'hFFFF, 4'd0);
		send_item(CMD_WRITE, 4'd15, 4'd15, 16'd7, 4'd0);
		send_item(CMD_WRITE, 4'd14, 4'd0, 16'd1, 4'd0);
		send_item(CMD_RUN, 4'd0, 4'd0, 16'd0, 4'd0);
		send_item(CMD_RUN, 4'hF, 4'hF, 16'hFFFF, 4'd15);
		// removing an edge with a zero weight
		send_item(CMD_WRITE, 4'd0, 4'd2, 16'd0, 4'd0);
		send_item(CMD_RUN, 4'd0, 4'd0, 16'd0, 4'd0);
		// source beyond the vertices in use
		set_vertex_count(5'd4);
		send_item(CMD_RUN, 4'd0, 4'd0, 16'd0, 4'd9);
		send_item(CMD_RUN, 4'd0, 4'd0, 16'd0, 4'd3);
		// count of zero behaves as one vertex
		set_vertex_count(5'd0);
		send_item(CMD_RUN, 4'd0, 4'd0, 16'd0, 4'd0);
		send_item(CMD_RUN, 4'd0, 4'd0, 16'd0, 4'd5);
		// count above sixteen is clamped
		set_vertex_count(5'd31);
		send_item(CMD_RUN, 4'd0, 4'd0, 16'd0, 4'd14);

		for (int p = 0; p < PHASES; p++) begin
			set_vertex_count(5'(PHASE_COUNTS[p]));
			n = (PHASE_COUNTS[p] == 0) ? 1 : (PHASE_COUNTS[p] > 16) ? 16 : PHASE_COUNTS[p];
			sender_idle_pct = SENDER_PCT[p % 4];
			receiver_stall_pct = RECEIVER_PCT[p % 4];
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				random_search(n);
				if (p == 1 && !pressure_done) begin
					wait_for_results();
					pressure_done = 1'b1;
				end
			end
		end

		wait_for_results();
		repeat (SEARCH_CYCLES) @(negedge clk);
		$display("tb_top: %0d input transfers (%0d searches), %0d vertex results checked",
			items_sent, searches_sent, results_checked);
		$display("tb_top: vertex counts 0..31 incl. clamped ones, four idle/stall patterns");
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb_top: timed out waiting for the core");
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
